>>> hdl/ira_pkg.sv
// Package for the rotation address map: configuration struct, mode codes,
// register indexes and the stage payload types passed between the pipeline stages.
// No dependencies.
package ira_pkg;

  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned FRAC_BITS = 14;

  localparam int unsigned DIM_W   = 13;            // clamped source size, 0..MAX_DIM
  localparam int unsigned PIX_W   = 12;            // in-bounds source coordinate
  localparam int unsigned COORD_W = 13;            // input col / row
  localparam int unsigned PITCH_W = 14;
  localparam int unsigned OFS_W   = 14;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned XY_W    = 15;            // col + min_x
  localparam int unsigned PROD_W  = XY_W + TRIG_W; // 31
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned Q_W     = SUM_W - FRAC_BITS;
  localparam int unsigned DPROD_W = COORD_W + PITCH_W;
  localparam int unsigned SPROD_W = PIX_W + DIM_W;
  localparam int unsigned SIDX_W  = 24;
  localparam int unsigned DIDX_W  = 26;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 16;
  localparam int unsigned IN_DW   = 32;
  localparam int unsigned OUT_DW  = 56;

  typedef enum logic [1:0] {
    MODE_GENERAL = 2'd0,
    MODE_ROT90   = 2'd1,
    MODE_ROT180  = 2'd2,
    MODE_ROT270  = 2'd3
  } ira_mode_t;

  localparam logic [CFG_AW-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_AW-1:0] REG_COS        = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SIN        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MIN_X      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MIN_Y      = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SRC_WIDTH  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_SRC_HEIGHT = 3'd6;
  localparam logic [CFG_AW-1:0] REG_DST_WIDTH  = 3'd7;

  typedef struct packed {
    ira_mode_t                  mode;
    logic signed [TRIG_W-1:0]   cos_q;
    logic signed [TRIG_W-1:0]   sin_q;
    logic signed [OFS_W-1:0]    min_x;
    logic signed [OFS_W-1:0]    min_y;
    logic        [DIM_W-1:0]    w;      // already clamped to MAX_DIM
    logic        [DIM_W-1:0]    h;
    logic        [PITCH_W-1:0]  pitch;
  } ira_cfg_t;

  typedef struct packed {
    logic                       general;
    logic signed [XY_W-1:0]     x;
    logic signed [XY_W-1:0]     y;
    logic                       dst_ok;
    logic        [COORD_W-1:0]  dst_row;
    logic        [COORD_W-1:0]  dst_col;
    logic                       q_valid;
    logic        [PIX_W-1:0]    q_row;
    logic        [PIX_W-1:0]    q_col;
  } ira_prep_t;

  typedef struct packed {
    logic                       general;
    logic signed [PROD_W-1:0]   xc;
    logic signed [PROD_W-1:0]   ys;
    logic signed [PROD_W-1:0]   yc;
    logic signed [PROD_W-1:0]   xs;
    logic                       dst_ok;
    logic        [DPROD_W-1:0]  dst_prod;
    logic        [COORD_W-1:0]  dst_col;
    logic                       q_valid;
    logic        [PIX_W-1:0]    q_row;
    logic        [PIX_W-1:0]    q_col;
  } ira_prod_t;

  typedef struct packed {
    logic                       src_ok;
    logic        [PIX_W-1:0]    s_row;
    logic        [PIX_W-1:0]    s_col;
    logic        [DIDX_W-1:0]   dst_index;
  } ira_sel_t;

  typedef struct packed {
    logic        [SIDX_W-1:0]   src_index;
    logic        [DIDX_W-1:0]   dst_index;
    logic                       copy_valid;
  } ira_res_t;

endpackage

>>> hdl/ira_prep.sv
// Stage 1: offsets the destination coordinate, or maps a source coordinate
// to its quadrant-rotated destination. Depends on ira_pkg.
module ira_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ira_pkg::ira_cfg_t             cfg,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [ira_pkg::COORD_W-1:0]   col,
  input  logic [ira_pkg::COORD_W-1:0]   row,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output ira_pkg::ira_prep_t            dn_data
);

  logic               valid_r;
  ira_pkg::ira_prep_t data_r;
  ira_pkg::ira_prep_t data_nxt;

  logic                           col_ok;
  logic                           q_ok;
  logic [ira_pkg::COORD_W-1:0]    h_last;
  logic [ira_pkg::COORD_W-1:0]    w_last;
  logic [ira_pkg::COORD_W-1:0]    dc;
  logic [ira_pkg::COORD_W-1:0]    dr;

  assign col_ok = {1'b0, col} < cfg.pitch;
  assign q_ok   = (col < cfg.w) && (row < cfg.h);
  assign h_last = cfg.h - row - 13'd1;
  assign w_last = cfg.w - col - 13'd1;

  always_comb begin
    unique case (cfg.mode)
      ira_pkg::MODE_ROT90: begin
        dc = h_last;
        dr = col;
      end
      ira_pkg::MODE_ROT180: begin
        dc = w_last;
        dr = h_last;
      end
      ira_pkg::MODE_ROT270: begin
        dc = row;
        dr = w_last;
      end
      ira_pkg::MODE_GENERAL: begin
        dc = col;
        dr = row;
      end
    endcase
  end

  always_comb begin
    data_nxt.general = (cfg.mode == ira_pkg::MODE_GENERAL);
    data_nxt.x = $signed({2'b00, col}) + $signed({cfg.min_x[ira_pkg::OFS_W-1], cfg.min_x});
    data_nxt.y = $signed({2'b00, row}) + $signed({cfg.min_y[ira_pkg::OFS_W-1], cfg.min_y});
    data_nxt.q_valid = q_ok;
    data_nxt.q_row   = q_ok ? row[ira_pkg::PIX_W-1:0] : '0;
    data_nxt.q_col   = q_ok ? col[ira_pkg::PIX_W-1:0] : '0;
    data_nxt.dst_ok  = data_nxt.general ? col_ok : q_ok;
    data_nxt.dst_row = data_nxt.dst_ok ? dr : '0;
    data_nxt.dst_col = data_nxt.dst_ok ? dc : '0;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> hdl/ira_mult.sv
// Stage 2: the four rotation products and the destination row times pitch,
// one multiplier deep. Depends on ira_pkg.
module ira_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  ira_pkg::ira_cfg_t   cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  ira_pkg::ira_prep_t  up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output ira_pkg::ira_prod_t  dn_data
);

  logic               valid_r;
  ira_pkg::ira_prod_t data_r;
  ira_pkg::ira_prod_t data_nxt;

  always_comb begin
    data_nxt.general  = up_data.general;
    data_nxt.xc       = up_data.x * cfg.cos_q;
    data_nxt.ys       = up_data.y * cfg.sin_q;
    data_nxt.yc       = up_data.y * cfg.cos_q;
    data_nxt.xs       = up_data.x * cfg.sin_q;
    data_nxt.dst_ok   = up_data.dst_ok;
    data_nxt.dst_prod = {{ira_pkg::PITCH_W{1'b0}}, up_data.dst_row}
                        * {{ira_pkg::COORD_W{1'b0}}, cfg.pitch};
    data_nxt.dst_col  = up_data.dst_col;
    data_nxt.q_valid  = up_data.q_valid;
    data_nxt.q_row    = up_data.q_row;
    data_nxt.q_col    = up_data.q_col;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> hdl/ira_trunc.sv
// Stage 3: sums the products, truncates toward zero, checks the source
// bounds and finishes the destination index. Depends on ira_pkg.
module ira_trunc (
  input  logic                clk,
  input  logic                rst_n,
  input  ira_pkg::ira_cfg_t   cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  ira_pkg::ira_prod_t  up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output ira_pkg::ira_sel_t   dn_data
);

  logic              valid_r;
  ira_pkg::ira_sel_t data_r;
  ira_pkg::ira_sel_t data_nxt;

  logic signed [ira_pkg::SUM_W-1:0]   sum_x;
  logic signed [ira_pkg::SUM_W-1:0]   sum_y;
  logic        [ira_pkg::Q_W-1:0]     sx;
  logic        [ira_pkg::Q_W-1:0]     sy;
  logic                               fix_x;
  logic                               fix_y;
  logic                               in_x;
  logic                               in_y;
  logic                               gen_ok;
  logic        [ira_pkg::DPROD_W-1:0] dst_sum;

  always_comb begin
    sum_x = $signed({up_data.xc[ira_pkg::PROD_W-1], up_data.xc})
          + $signed({up_data.ys[ira_pkg::PROD_W-1], up_data.ys});
    sum_y = $signed({up_data.yc[ira_pkg::PROD_W-1], up_data.yc})
          - $signed({up_data.xs[ira_pkg::PROD_W-1], up_data.xs});
    // floor plus one for a negative value with a nonzero fraction
    fix_x = sum_x[ira_pkg::SUM_W-1] && (|sum_x[ira_pkg::FRAC_BITS-1:0]);
    fix_y = sum_y[ira_pkg::SUM_W-1] && (|sum_y[ira_pkg::FRAC_BITS-1:0]);
    sx = sum_x[ira_pkg::SUM_W-1:ira_pkg::FRAC_BITS] + {{(ira_pkg::Q_W-1){1'b0}}, fix_x};
    sy = sum_y[ira_pkg::SUM_W-1:ira_pkg::FRAC_BITS] + {{(ira_pkg::Q_W-1){1'b0}}, fix_y};
    in_x = !sx[ira_pkg::Q_W-1]
           && (sx[ira_pkg::Q_W-2:0] < {{(ira_pkg::Q_W-1-ira_pkg::DIM_W){1'b0}}, cfg.w});
    in_y = !sy[ira_pkg::Q_W-1]
           && (sy[ira_pkg::Q_W-2:0] < {{(ira_pkg::Q_W-1-ira_pkg::DIM_W){1'b0}}, cfg.h});
    gen_ok = up_data.dst_ok && in_x && in_y;

    dst_sum = up_data.dst_prod + {{ira_pkg::PITCH_W{1'b0}}, up_data.dst_col};
    data_nxt.dst_index = dst_sum[ira_pkg::DIDX_W-1:0];

    if (up_data.general) begin
      data_nxt.src_ok = gen_ok;
      data_nxt.s_row  = gen_ok ? sy[ira_pkg::PIX_W-1:0] : '0;
      data_nxt.s_col  = gen_ok ? sx[ira_pkg::PIX_W-1:0] : '0;
    end else begin
      data_nxt.src_ok = up_data.q_valid;
      data_nxt.s_row  = up_data.q_row;
      data_nxt.s_col  = up_data.q_col;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> hdl/ira_index.sv
// Stages 4 and 5: source row times width, then the column add into the
// output register. Depends on ira_pkg.
module ira_index (
  input  logic               clk,
  input  logic               rst_n,
  input  ira_pkg::ira_cfg_t  cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  ira_pkg::ira_sel_t  up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output ira_pkg::ira_res_t  dn_data
);

  typedef struct packed {
    logic                             src_ok;
    logic [ira_pkg::SPROD_W-1:0]      s_prod;
    logic [ira_pkg::PIX_W-1:0]        s_col;
    logic [ira_pkg::DIDX_W-1:0]       dst_index;
  } mul_t;

  logic              mul_valid_r;
  mul_t              mul_r;
  mul_t              mul_nxt;
  logic              mul_ready;
  logic              res_valid_r;
  ira_pkg::ira_res_t res_r;
  ira_pkg::ira_res_t res_nxt;
  logic [ira_pkg::SPROD_W-1:0] s_sum;

  always_comb begin
    mul_nxt.src_ok    = up_data.src_ok;
    mul_nxt.s_prod    = {{ira_pkg::DIM_W{1'b0}}, up_data.s_row}
                        * {{ira_pkg::PIX_W{1'b0}}, cfg.w};
    mul_nxt.s_col     = up_data.s_col;
    mul_nxt.dst_index = up_data.dst_index;
  end

  always_comb begin
    s_sum = mul_r.s_prod + {{ira_pkg::DIM_W{1'b0}}, mul_r.s_col};
    res_nxt.src_index  = s_sum[ira_pkg::SIDX_W-1:0];
    res_nxt.dst_index  = mul_r.dst_index;
    res_nxt.copy_valid = mul_r.src_ok;
  end

  assign mul_ready = !res_valid_r || dn_ready;
  assign up_ready  = !mul_valid_r || mul_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        mul_valid_r <= up_valid;
      end
      if (mul_ready) begin
        res_valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      mul_r <= mul_nxt;
    end
    if (mul_ready && mul_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid = res_valid_r;
  assign dn_data  = res_r;

endmodule

>>> hdl/image_rotate_address_map.sv
// Top level of the rotation address map: configuration registers and the
// five-stage pipeline. Depends on ira_pkg, ira_prep, ira_mult, ira_trunc, ira_index.
//
// Usage:
//   in_*  : one pixel coordinate per transaction (col, row). In general mode it
//           is a destination pixel; in the 90/180/270 modes a source pixel.
//   out_* : one result per input transaction, in order: source index,
//           destination index and copy-valid flag.
//   cfg_* : register write port, index 0..7 = mode, cos_q, sin_q, min_x, min_y,
//           src_width, src_height, dst_width. Write only while the pipeline is
//           empty. Source sizes whose low 13 bits exceed 4096 are stored as 4096.
// The pipeline takes one transaction per cycle while out_tready keeps the
// output moving; the stages are split at the rotation multipliers,
// the truncate/bounds adders and the source row multiplier.
// Reset clears all stage valid bits and loads the register reset values
// (identity rotation, 4096 x 4096). When the receiver stalls, each stage holds
// its item and the stall reaches in_tready only once every stage is full, so
// empty slots are filled while the output waits.
module image_rotate_address_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ira_pkg::IN_DW-1:0]     in_tdata,   // col[12:0], row[25:13], zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ira_pkg::OUT_DW-1:0]    out_tdata,  // src_index[23:0], dst_index[49:24],
                                                    // copy_valid[50], zero pad
  input  logic                          cfg_we,
  input  logic [ira_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [ira_pkg::CFG_DW-1:0]    cfg_wdata
);

  ira_pkg::ira_cfg_t  cfg_r;
  logic [ira_pkg::DIM_W-1:0] dim_nxt;

  logic               prep_valid;
  logic               prep_ready;
  ira_pkg::ira_prep_t prep_data;
  logic               prod_valid;
  logic               prod_ready;
  ira_pkg::ira_prod_t prod_data;
  logic               sel_valid;
  logic               sel_ready;
  ira_pkg::ira_sel_t  sel_data;
  ira_pkg::ira_res_t  res_data;

  assign dim_nxt = (cfg_wdata[ira_pkg::DIM_W-1:0] > ira_pkg::DIM_W'(ira_pkg::MAX_DIM))
                   ? ira_pkg::DIM_W'(ira_pkg::MAX_DIM) : cfg_wdata[ira_pkg::DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= ira_pkg::MODE_GENERAL;
      cfg_r.cos_q <= ira_pkg::TRIG_W'(1 << ira_pkg::FRAC_BITS);
      cfg_r.sin_q <= '0;
      cfg_r.min_x <= '0;
      cfg_r.min_y <= '0;
      cfg_r.w     <= ira_pkg::DIM_W'(ira_pkg::MAX_DIM);
      cfg_r.h     <= ira_pkg::DIM_W'(ira_pkg::MAX_DIM);
      cfg_r.pitch <= ira_pkg::PITCH_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ira_pkg::REG_MODE:       cfg_r.mode  <= ira_pkg::ira_mode_t'(cfg_wdata[1:0]);
        ira_pkg::REG_COS:        cfg_r.cos_q <= cfg_wdata[ira_pkg::TRIG_W-1:0];
        ira_pkg::REG_SIN:        cfg_r.sin_q <= cfg_wdata[ira_pkg::TRIG_W-1:0];
        ira_pkg::REG_MIN_X:      cfg_r.min_x <= cfg_wdata[ira_pkg::OFS_W-1:0];
        ira_pkg::REG_MIN_Y:      cfg_r.min_y <= cfg_wdata[ira_pkg::OFS_W-1:0];
        ira_pkg::REG_SRC_WIDTH:  cfg_r.w     <= dim_nxt;
        ira_pkg::REG_SRC_HEIGHT: cfg_r.h     <= dim_nxt;
        ira_pkg::REG_DST_WIDTH:  cfg_r.pitch <= cfg_wdata[ira_pkg::PITCH_W-1:0];
      endcase
    end
  end

  ira_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .col      (in_tdata[12:0]),
    .row      (in_tdata[25:13]),
    .dn_valid (prep_valid),
    .dn_ready (prep_ready),
    .dn_data  (prep_data)
  );

  ira_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (prep_valid),
    .up_ready (prep_ready),
    .up_data  (prep_data),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  ira_trunc u_trunc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_data  (prod_data),
    .dn_valid (sel_valid),
    .dn_ready (sel_ready),
    .dn_data  (sel_data)
  );

  ira_index u_index (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (sel_valid),
    .up_ready (sel_ready),
    .up_data  (sel_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res_data)
  );

  assign out_tdata = {5'd0, res_data.copy_valid, res_data.dst_index, res_data.src_index};

  // a pixel outside the source never carries a source index
  a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[50] |-> out_tdata[23:0] == '0)
    else $error("source index nonzero on invalid copy");

  a_quad_dst_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[50] && cfg_r.mode != ira_pkg::MODE_GENERAL
    |-> out_tdata[49:24] == '0)
    else $error("quadrant destination index nonzero on invalid copy");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
